### design/awsb_pkg.sv
// Package for the acknowledgement window scoreboard.
// Holds the field widths, the action and status codes, the table entry and the sequencer states.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package awsb_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int ACTION_W = 3;
	localparam int SEQ_W    = 32;
	localparam int SIZE_W   = 16;
	localparam int BYTES_W  = 20;
	localparam int STATUS_W = 2;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT  = 3'd0,
		ACT_REMOVE  = 3'd1,
		ACT_MARK    = 3'd2,
		ACT_QUERY   = 3'd3,
		ACT_ADVANCE = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0] size;
		logic              acked;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADV,
		ST_SHIFT,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

### design/awsb_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Used for the scoreboard's entry table; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module awsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/ack_window_scoreboard.sv
// Top level of the acknowledgement window scoreboard: sequencer, entry count and result register.
// Depends on awsb_pkg and on awsb_ram, which holds the ordered table of entries.
//
// The scoreboard keeps an ordered table of outstanding segments in one RAM with a single read
// and a single write port, and takes one item at a time. Insert, clear and the unused action
// codes go from acceptance straight to the finishing state. Remove, mark and query walk the
// table from the oldest entry, one RAM read per cycle, up to and including the match; a remove
// then closes the gap by copying every younger entry down one place, one entry per cycle.
// Advance walks the leading run of acknowledged entries the same way and then copies the
// remaining entries down in one pass. The worst case is an advance that pops some but not all
// of the entries, since the single RAM read port serves both the walk and the copy. The result
// waits in an output register, so the next item is taken while it is still held by the far
// side.
`timescale 1ns / 1ps
`default_nettype none

module ack_window_scoreboard #(
	parameter int TABLE_DEPTH = awsb_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [awsb_pkg::ACTION_W-1:0] action,
	input  wire logic [awsb_pkg::SEQ_W-1:0]    seq_number,
	input  wire logic [awsb_pkg::SIZE_W-1:0]   segment_size,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               acked,
	output logic      [awsb_pkg::BYTES_W-1:0]  advance_bytes,
	output logic      [awsb_pkg::STATUS_W-1:0] status
);

	import awsb_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	action_t           action_q, action_d;
	logic [SEQ_W-1:0]  seq_q, seq_d;
	logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
	logic              cmp_vld_s1, cmp_vld_d;
	logic [IDX_W-1:0]  cmp_idx_s1, cmp_idx_d;
	logic [CNT_W-1:0]  gap_q, gap_d;
	logic              res_acked_q, res_acked_d;
	logic [BYTES_W-1:0] res_bytes_q, res_bytes_d;
	status_t           res_status_q, res_status_d;
	logic              out_valid_q, out_valid_d;
	logic              out_load;
	logic              acked_q;
	logic [BYTES_W-1:0] advance_bytes_q;
	status_t           status_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_entry;

	logic              more_rd;
	logic              hit;
	logic [CNT_W-1:0]  cmp_idx_ext;
	logic [CNT_W-1:0]  shift_dst;
	logic [BYTES_W:0]  bytes_sum;
	logic [BYTES_W-1:0] bytes_sat;

	awsb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign rd_entry    = entry_t'(ram_rdata);
	assign more_rd     = (scan_idx_q < count_q);
	assign hit         = cmp_vld_s1 && (rd_entry.seq == seq_q);
	assign cmp_idx_ext = CNT_W'(cmp_idx_s1);
	assign shift_dst   = cmp_idx_ext - gap_q;
	assign bytes_sum   = {1'b0, res_bytes_q} + (BYTES_W + 1)'(rd_entry.size);
	assign bytes_sat   = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			cmp_vld_s1  <= cmp_vld_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		action_q     <= action_d;
		seq_q        <= seq_d;
		scan_idx_q   <= scan_idx_d;
		cmp_idx_s1   <= cmp_idx_d;
		gap_q        <= gap_d;
		res_acked_q  <= res_acked_d;
		res_bytes_q  <= res_bytes_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			acked_q         <= res_acked_q;
			advance_bytes_q <= res_bytes_q;
			status_q        <= res_status_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		action_d     = action_q;
		seq_d        = seq_q;
		scan_idx_d   = scan_idx_q;
		cmp_vld_d    = 1'b0;
		cmp_idx_d    = cmp_idx_s1;
		gap_d        = gap_q;
		res_acked_d  = res_acked_q;
		res_bytes_d  = res_bytes_q;
		res_status_d = res_status_q;
		out_valid_d  = out_valid_q & out_stall;
		out_load     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					action_d     = action_t'(action);
					seq_d        = seq_number;
					scan_idx_d   = '0;
					res_acked_d  = 1'b0;
					res_bytes_d  = '0;
					res_status_d = STATUS_OK;
					state_d      = ST_FINISH;
					case (action_t'(action))
						ACT_INSERT: begin
							if (count_q == DEPTH_CNT) begin
								res_status_d = STATUS_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[IDX_W-1:0];
								ram_wdata = '{seq: seq_number, size: segment_size, acked: 1'b0};
								count_d   = count_q + 1'b1;
							end
						end
						ACT_REMOVE, ACT_MARK, ACT_QUERY: begin
							state_d = ST_SCAN;
						end
						ACT_ADVANCE: begin
							state_d = ST_ADV;
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end

			ST_SCAN: begin
				if (hit) begin
					case (action_q)
						ACT_MARK: begin
							ram_we    = 1'b1;
							ram_waddr = cmp_idx_s1;
							ram_wdata = '{seq: rd_entry.seq, size: rd_entry.size, acked: 1'b1};
							state_d   = ST_FINISH;
						end
						ACT_QUERY: begin
							res_acked_d = rd_entry.acked;
							state_d     = ST_FINISH;
						end
						default: begin
							gap_d      = CNT_W'(1);
							scan_idx_d = cmp_idx_ext + CNT_W'(1);
							state_d    = ST_SHIFT;
						end
					endcase
				end else if (more_rd) begin
					ram_re     = 1'b1;
					ram_raddr  = scan_idx_q[IDX_W-1:0];
					cmp_vld_d  = 1'b1;
					cmp_idx_d  = scan_idx_q[IDX_W-1:0];
					scan_idx_d = scan_idx_q + 1'b1;
				end else if (!cmp_vld_s1) begin
					res_status_d = STATUS_NOT_FOUND;
					res_acked_d  = (action_q == ACT_QUERY);
					state_d      = ST_FINISH;
				end
			end

			ST_ADV: begin
				if (cmp_vld_s1 && !rd_entry.acked) begin
					gap_d      = cmp_idx_ext;
					scan_idx_d = cmp_idx_ext;
					state_d    = (cmp_idx_s1 == '0) ? ST_FINISH : ST_SHIFT;
				end else begin
					if (cmp_vld_s1) begin
						res_bytes_d = bytes_sat;
					end
					if (more_rd) begin
						ram_re     = 1'b1;
						ram_raddr  = scan_idx_q[IDX_W-1:0];
						cmp_vld_d  = 1'b1;
						cmp_idx_d  = scan_idx_q[IDX_W-1:0];
						scan_idx_d = scan_idx_q + 1'b1;
					end else if (!cmp_vld_s1) begin
						count_d = '0;
						state_d = ST_FINISH;
					end
				end
			end

			ST_SHIFT: begin
				if (cmp_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = shift_dst[IDX_W-1:0];
					ram_wdata = rd_entry;
				end
				if (more_rd) begin
					ram_re     = 1'b1;
					ram_raddr  = scan_idx_q[IDX_W-1:0];
					cmp_vld_d  = 1'b1;
					cmp_idx_d  = scan_idx_q[IDX_W-1:0];
					scan_idx_d = scan_idx_q + 1'b1;
				end else if (!cmp_vld_s1) begin
					count_d = count_q - gap_q;
					state_d = ST_FINISH;
				end
			end

			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign acked         = acked_q;
	assign advance_bytes = advance_bytes_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("Entry count has gone beyond the table depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (scan_idx_q < count_q))
		else $error("Table read beyond the valid entries.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && ram_we) |-> (shift_dst < cmp_idx_ext))
		else $error("Gap closing wrote at or above its source entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ACT_INSERT && count_q != DEPTH_CNT)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("Accepted insert did not grow the table by one entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_OK) |-> (advance_bytes == '0))
		else $error("Failed item reported advanced bytes.");
`endif

endmodule

`default_nettype wire
